// File: design/ebw_pkg.sv
// Shared types and constants for the body-to-world offset rotation block.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package ebw_pkg;

    // Angle format inside the sine/cosine path: Q16 radians
    localparam int ZW = 20;
    // CORDIC x/y working width (Q30 with headroom)
    localparam int XW = 34;
    // Sine, cosine and matrix entries: signed Q30
    localparam int SW = 32;
    // Measured offsets
    localparam int MW = 15;
    // Negated offsets need one extra bit
    localparam int BW = 16;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_SPS   = 4;
    localparam int CORDIC_NS    = CORDIC_STEPS / CORDIC_SPS;

    localparam logic signed [ZW-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW+2:0] TWO_PI_Q16  = 23'sd411775;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
        20'sd256,   20'sd128,   20'sd64,    20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2
    };

    typedef struct packed {
        logic signed [BW-1:0] bx;
        logic signed [BW-1:0] by;
        logic signed [MW-1:0] bz;
    } t_side;

    // Product of two Q30 values, floored back to Q30
    function automatic logic signed [SW-1:0] mul30(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
        logic signed [2*SW-1:0] p;
        p = (2*SW)'(a) * (2*SW)'(b);
        return p[SW+29:30];
    endfunction

endpackage

`default_nettype wire

// File: design/ebw_angle_prep.sv
// Angle conversion to Q16 radians, wrap into [-pi, pi] and fold into [-pi/2, pi/2].
// Uses ebw_pkg for the angle constants.
`default_nettype none

module ebw_angle_prep #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic signed [15:0]         i_angle,
    output logic signed [ebw_pkg::ZW-1:0]   o_z,
    output logic                            o_flip
);
    import ebw_pkg::*;

    localparam int QW = 23;
    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam int LS = (SH >= 0) ? SH : 0;
    localparam int RS = (SH < 0) ? -SH : 1;
    // whole turns that the widest converted code can hold
    localparam int NWRAP = ((32768 << LS) - 205887 + 411774) / 411775;
    localparam logic signed [QW-1:0] RND = QW'(1) << (RS - 1);
    localparam logic signed [QW-1:0] PI_W = QW'(PI_Q16);
    localparam logic signed [QW-1:0] HP_W = QW'(HALF_PI_Q16);

    logic signed [QW-1:0] a_ext;
    logic signed [QW-1:0] q;

    assign a_ext = QW'(i_angle);

    always_comb begin
        if (SH >= 0) begin
            q = a_ext <<< LS;
        end else begin
            q = (a_ext + RND) >>> RS;
        end
        // remove whole turns, one per step
        for (int k = 0; k < NWRAP; k++) begin
            if (q > PI_W) begin
                q = q - TWO_PI_Q16;
            end else if (q < -PI_W) begin
                q = q + TWO_PI_Q16;
            end
        end
        o_flip = 1'b0;
        if (q > HP_W) begin
            q      = q - PI_W;
            o_flip = 1'b1;
        end else if (q < -HP_W) begin
            q      = q + PI_W;
            o_flip = 1'b1;
        end
        o_z = ZW'(q);
    end

endmodule

`default_nettype wire

// File: design/ebw_cordic.sv
// Pipelined rotation-mode CORDIC: four register stages of four steps each.
// Uses ebw_pkg for the arctangent table, gain and widths.
`default_nettype none

module ebw_cordic (
    input  wire logic                             i_clk,
    input  wire logic [ebw_pkg::CORDIC_NS-1:0]    i_en,
    input  wire logic signed [ebw_pkg::ZW-1:0]    i_z,
    input  wire logic                             i_flip,
    output logic signed [ebw_pkg::SW-1:0]         o_sin,
    output logic signed [ebw_pkg::SW-1:0]         o_cos
);
    import ebw_pkg::*;

    localparam int NS = CORDIC_NS;

    logic signed [XW-1:0] r_x [NS];
    logic signed [XW-1:0] r_y [NS];
    logic signed [ZW-1:0] r_z [NS];
    logic                 r_f [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic signed [XW-1:0] a_x, a_y, n_x, n_y, t_x;
        logic signed [ZW-1:0] a_z, n_z;
        logic                 a_f;

        if (s == 0) begin : g_in
            assign a_x = CORDIC_GAIN;
            assign a_y = '0;
            assign a_z = i_z;
            assign a_f = i_flip;
        end else begin : g_chain
            assign a_x = r_x[s-1];
            assign a_y = r_y[s-1];
            assign a_z = r_z[s-1];
            assign a_f = r_f[s-1];
        end

        always_comb begin
            n_x = a_x;
            n_y = a_y;
            n_z = a_z;
            t_x = a_x;
            for (int j = 0; j < CORDIC_SPS; j++) begin
                if (!n_z[ZW-1]) begin
                    t_x = n_x - (n_y >>> (s * CORDIC_SPS + j));
                    n_y = n_y + (n_x >>> (s * CORDIC_SPS + j));
                    n_z = n_z - ATAN_Q16[s * CORDIC_SPS + j];
                end else begin
                    t_x = n_x + (n_y >>> (s * CORDIC_SPS + j));
                    n_y = n_y - (n_x >>> (s * CORDIC_SPS + j));
                    n_z = n_z + ATAN_Q16[s * CORDIC_SPS + j];
                end
                n_x = t_x;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_x[s] <= n_x;
                r_y[s] <= n_y;
                r_z[s] <= n_z;
                r_f[s] <= a_f;
            end
        end
    end

    // undo the half-turn fold
    assign o_sin = r_f[NS-1] ? SW'(-r_y[NS-1]) : SW'(r_y[NS-1]);
    assign o_cos = r_f[NS-1] ? SW'(-r_x[NS-1]) : SW'(r_x[NS-1]);

endmodule

`default_nettype wire

// File: design/ebw_rot_matrix.sv
// First two rows of the ZYX rotation matrix in three register stages.
// Uses ebw_pkg for widths and the Q30 product function.
`default_nettype none

module ebw_rot_matrix (
    input  wire logic                          i_clk,
    input  wire logic [2:0]                    i_en,
    input  wire logic signed [ebw_pkg::SW-1:0] i_sr,
    input  wire logic signed [ebw_pkg::SW-1:0] i_cr,
    input  wire logic signed [ebw_pkg::SW-1:0] i_sp,
    input  wire logic signed [ebw_pkg::SW-1:0] i_cp,
    input  wire logic signed [ebw_pkg::SW-1:0] i_sy,
    input  wire logic signed [ebw_pkg::SW-1:0] i_cy,
    output logic signed [ebw_pkg::SW-1:0]      o_r00,
    output logic signed [ebw_pkg::SW-1:0]      o_r01,
    output logic signed [ebw_pkg::SW-1:0]      o_r02,
    output logic signed [ebw_pkg::SW-1:0]      o_r10,
    output logic signed [ebw_pkg::SW-1:0]      o_r11,
    output logic signed [ebw_pkg::SW-1:0]      o_r12
);
    import ebw_pkg::*;

    logic signed [SW-1:0] r_srsp, r_crsp, r_a00, r_a10, r_sr, r_cr, r_sy, r_cy;
    logic signed [SW-1:0] r_t [8];
    logic signed [SW-1:0] r_b00, r_b10;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_srsp <= mul30(i_sr, i_sp);
            r_crsp <= mul30(i_cr, i_sp);
            r_a00  <= mul30(i_cp, i_cy);
            r_a10  <= mul30(i_cp, i_sy);
            r_sr   <= i_sr;
            r_cr   <= i_cr;
            r_sy   <= i_sy;
            r_cy   <= i_cy;
        end
        if (i_en[1]) begin
            r_t[0] <= mul30(r_srsp, r_cy);
            r_t[1] <= mul30(r_cr, r_sy);
            r_t[2] <= mul30(r_crsp, r_cy);
            r_t[3] <= mul30(r_sr, r_sy);
            r_t[4] <= mul30(r_srsp, r_sy);
            r_t[5] <= mul30(r_cr, r_cy);
            r_t[6] <= mul30(r_crsp, r_sy);
            r_t[7] <= mul30(r_sr, r_cy);
            r_b00  <= r_a00;
            r_b10  <= r_a10;
        end
        if (i_en[2]) begin
            o_r00 <= r_b00;
            o_r01 <= r_t[0] - r_t[1];
            o_r02 <= r_t[2] + r_t[3];
            o_r10 <= r_b10;
            o_r11 <= r_t[4] + r_t[5];
            o_r12 <= r_t[6] - r_t[7];
        end
    end

endmodule

`default_nettype wire

// File: design/euler_body_to_world_offset.sv
// Body-to-world offset rotation, top level: angle prep, CORDIC, matrix and output math.
// Depends on ebw_pkg, ebw_angle_prep, ebw_cordic and ebw_rot_matrix.
//
// Usage: an input transfer carries roll, pitch, yaw (signed Q radians), the
// measured body offset and the base position. Each input transfer yields one
// output transfer with world x/y (rotated, base added, saturated) and z.
// Both channels use valid/stall: a transfer happens on a clock edge with valid
// high and stall low.
// Throughput is one item per cycle while the output is not stalled, set by the
// 11-stage pipeline (angle prep in 1, 3 sine/cosine units of 4 stages, matrix in 3,
// dot products in 3).
// A stalled output holds its data; earlier stages keep filling their empty
// slots, so o_stall rises only once every stage holds an item.
// Reset (synchronous, active low) clears all valid bits; data registers are
// not reset.
`default_nettype none

module euler_body_to_world_offset #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int COORD_WIDTH     = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [15:0]             i_roll,
    input  wire logic signed [15:0]             i_pitch,
    input  wire logic signed [15:0]             i_yaw,
    input  wire logic signed [ebw_pkg::MW-1:0]  i_meas_x,
    input  wire logic signed [ebw_pkg::MW-1:0]  i_meas_y,
    input  wire logic signed [ebw_pkg::MW-1:0]  i_meas_z,
    input  wire logic signed [COORD_WIDTH-1:0]  i_base_a,
    input  wire logic signed [COORD_WIDTH-1:0]  i_base_b,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [COORD_WIDTH-1:0]       o_world_x,
    output logic signed [COORD_WIDTH-1:0]       o_world_y,
    output logic signed [ebw_pkg::MW-1:0]       o_world_z
);
    import ebw_pkg::*;

    localparam int NST = 11;
    localparam int PW  = SW + BW;
    localparam int AW  = PW + 4;
    localparam int FW  = COORD_WIDTH + 8;
    localparam logic signed [AW-1:0] ROUND = AW'(1) << 29;
    localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [FW-1:0] SAT_LO = FW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    logic [NST:1] r_v;
    logic [NST:1] en;

    // stage k may load when it is empty or stage k+1 moves on
    always_comb begin
        en[NST] = !r_v[NST] || !i_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: angle prep
    logic signed [ZW-1:0] z_r, z_p, z_y;
    logic                 f_r, f_p, f_y;
    logic signed [ZW-1:0] r_z1 [3];
    logic                 r_f1 [3];

    ebw_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_r (
        .i_angle(i_roll),  .o_z(z_r), .o_flip(f_r));
    ebw_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_p (
        .i_angle(i_pitch), .o_z(z_p), .o_flip(f_p));
    ebw_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_y (
        .i_angle(i_yaw),   .o_z(z_y), .o_flip(f_y));

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_z1[0] <= z_r;
            r_z1[1] <= z_p;
            r_z1[2] <= z_y;
            r_f1[0] <= f_r;
            r_f1[1] <= f_p;
            r_f1[2] <= f_y;
        end
    end

    // side payload travels with the item
    t_side                   r_side [1:10];
    logic signed [COORD_WIDTH-1:0] r_ba [1:10];
    logic signed [COORD_WIDTH-1:0] r_bb [1:10];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_side[1].bx <= -BW'(i_meas_x);
            r_side[1].by <= -BW'(i_meas_y);
            r_side[1].bz <= i_meas_z;
            r_ba[1]      <= i_base_a;
            r_bb[1]      <= i_base_b;
        end
        for (int k = 2; k <= 10; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
                r_ba[k]   <= r_ba[k-1];
                r_bb[k]   <= r_bb[k-1];
            end
        end
    end

    // stages 2..5: sine and cosine
    logic signed [SW-1:0] sr, cr, sp, cp, sy, cy;

    ebw_cordic u_cordic_r (.i_clk(i_clk), .i_en(en[5:2]), .i_z(r_z1[0]),
        .i_flip(r_f1[0]), .o_sin(sr), .o_cos(cr));
    ebw_cordic u_cordic_p (.i_clk(i_clk), .i_en(en[5:2]), .i_z(r_z1[1]),
        .i_flip(r_f1[1]), .o_sin(sp), .o_cos(cp));
    ebw_cordic u_cordic_y (.i_clk(i_clk), .i_en(en[5:2]), .i_z(r_z1[2]),
        .i_flip(r_f1[2]), .o_sin(sy), .o_cos(cy));

    // stages 6..8: matrix rows
    logic signed [SW-1:0] r00, r01, r02, r10, r11, r12;

    ebw_rot_matrix u_matrix (
        .i_clk(i_clk), .i_en(en[8:6]),
        .i_sr(sr), .i_cr(cr), .i_sp(sp), .i_cp(cp), .i_sy(sy), .i_cy(cy),
        .o_r00(r00), .o_r01(r01), .o_r02(r02),
        .o_r10(r10), .o_r11(r11), .o_r12(r12));

    // stage 9: row times body vector, stage 10: row sums, stage 11: finish
    logic signed [PW-1:0] r_p [6];
    logic signed [AW-1:0] r_acc0, r_acc1;
    logic signed [FW-1:0] n_x, n_y, s_x, s_y;

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_p[0] <= PW'(r00) * PW'(r_side[8].bx);
            r_p[1] <= PW'(r01) * PW'(r_side[8].by);
            r_p[2] <= PW'(r02) * PW'(r_side[8].bz);
            r_p[3] <= PW'(r10) * PW'(r_side[8].bx);
            r_p[4] <= PW'(r11) * PW'(r_side[8].by);
            r_p[5] <= PW'(r12) * PW'(r_side[8].bz);
        end
        if (en[10]) begin
            r_acc0 <= AW'(r_p[0]) + AW'(r_p[1]) + AW'(r_p[2]) + ROUND;
            r_acc1 <= AW'(r_p[3]) + AW'(r_p[4]) + AW'(r_p[5]) + ROUND;
        end
    end

    always_comb begin
        n_x = FW'(r_acc0 >>> 30) + FW'(r_bb[10]);
        n_y = FW'(r_acc1 >>> 30) + FW'(r_ba[10]);
        s_x = (n_x > SAT_HI) ? SAT_HI : ((n_x < SAT_LO) ? SAT_LO : n_x);
        s_y = (n_y > SAT_HI) ? SAT_HI : ((n_y < SAT_LO) ? SAT_LO : n_y);
    end

    always_ff @(posedge i_clk) begin
        if (en[NST]) begin
            o_world_x <= COORD_WIDTH'(s_x);
            o_world_y <= COORD_WIDTH'(s_y);
            o_world_z <= r_side[10].bz;
        end
    end

    // back-pressure reaches the input only when the output slot is full
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output slot empty");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[1])
        else $error("accepted transfer lost at first stage");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
